// File: rtl/point_transform_2d_top_assert.svh
`ifndef POINT_TRANSFORM_2D_TOP_ASSERT_SVH
`define POINT_TRANSFORM_2D_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define PT2D_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PT2D_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define PT2D_ASSERT_NXT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/pt2d_pkg.sv
`timescale 1ns / 1ps

package pt2d_pkg;

    // Transform modes
    typedef enum logic [2:0] {
        MODE_SCALE   = 3'd0,
        MODE_REFL_X  = 3'd1,
        MODE_REFL_Y  = 3'd2,
        MODE_REFL_O  = 3'd3,
        MODE_SWAP    = 3'd4,
        MODE_ROTATE  = 3'd5
    } pt2d_mode_t;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PIVOT_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PIVOT_Y = 3'd5;

    // Angle folding
    localparam logic [8:0] ANGLE_FULL = 9'd360;
    localparam logic [8:0] ANGLE_270  = 9'd270;
    localparam logic [8:0] ANGLE_180  = 9'd180;
    localparam logic [8:0] ANGLE_90   = 9'd90;
    localparam logic [6:0] DEG_90     = 7'd90;

    // Fixed datapath widths
    localparam int SPROD_W     = 28;
    localparam int SCALE_SHIFT = 8;
    localparam int VAL_W       = 21;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [15:0] scale_x;
        logic signed [15:0] scale_y;
        logic [8:0]         angle_deg;
        logic signed [11:0] pivot_x;
        logic signed [11:0] pivot_y;
    } pt2d_cfg_t;

    localparam pt2d_cfg_t CFG_RESET = '{
        mode:      MODE_SCALE,
        scale_x:   16'sd256,
        scale_y:   16'sd256,
        angle_deg: 9'd0,
        pivot_x:   12'sd0,
        pivot_y:   12'sd0
    };

    // First stage payload: decoded request
    typedef struct packed {
        logic [2:0]         mode;
        logic [1:0]         quad;
        logic [6:0]         rem;
        logic signed [12:0] dx;
        logic signed [12:0] dy;
        logic signed [11:0] px;
        logic signed [11:0] py;
        logic signed [11:0] cx;
        logic signed [11:0] cy;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [12:0] dir_x;
        logic signed [12:0] dir_y;
    } pt2d_s1_t;

    // Control carried alongside the products
    typedef struct packed {
        logic [2:0]         mode;
        logic signed [11:0] cx;
        logic signed [11:0] cy;
        logic signed [12:0] dir_x;
        logic signed [12:0] dir_y;
    } pt2d_ctl_t;

    // sin(0..90 degrees) in Q1.14, rounded to nearest
    localparam logic [14:0] SIN_Q14 [0:90] = '{
        15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,
        15'd1428,  15'd1713,  15'd1997,  15'd2280,  15'd2563,
        15'd2845,  15'd3126,  15'd3406,  15'd3686,  15'd3964,
        15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,
        15'd5604,  15'd5872,  15'd6138,  15'd6402,  15'd6664,
        15'd6924,  15'd7182,  15'd7438,  15'd7692,  15'd7943,
        15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
        15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311,
        15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381,
        15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
        15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
        15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
        15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726,
        15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
        15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
        15'd15826, 15'd15897, 15'd15964, 15'd16026, 15'd16083,
        15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
        15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
        15'd16384
    };

    // Look up sine, clamping the angle at ninety degrees
    function automatic logic [14:0] pt2d_sin_q14(input logic [6:0] deg);
        logic [6:0] idx;
        idx = (deg > DEG_90) ? DEG_90 : deg;
        return SIN_Q14[idx];
    endfunction

endpackage

// File: rtl/pt2d_front.sv
`timescale 1ns / 1ps

module pt2d_front import pt2d_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [11:0] point_x,
    input  logic signed [11:0] point_y,
    input  pt2d_cfg_t          cfg,
    output logic               out_valid,
    input  logic               out_ready,
    output pt2d_s1_t           out_data
);

    logic     valid_reg;
    pt2d_s1_t data_reg;
    pt2d_s1_t data_next;

    // Decode the request: fold the angle, form offsets and the direct results
    always_comb begin
        logic [8:0]         ang;
        logic signed [12:0] px13;
        logic signed [12:0] py13;
        ang  = (cfg.angle_deg >= ANGLE_FULL) ? (cfg.angle_deg - ANGLE_FULL) : cfg.angle_deg;
        px13 = 13'(point_x);
        py13 = 13'(point_y);

        data_next       = '0;
        data_next.mode  = cfg.mode;
        data_next.px    = point_x;
        data_next.py    = point_y;
        data_next.cx    = cfg.pivot_x;
        data_next.cy    = cfg.pivot_y;
        data_next.sx    = cfg.scale_x;
        data_next.sy    = cfg.scale_y;
        data_next.dx    = px13 - 13'(cfg.pivot_x);
        data_next.dy    = py13 - 13'(cfg.pivot_y);

        priority if (ang >= ANGLE_270) begin
            data_next.quad = 2'd3;
            data_next.rem  = 7'(ang - ANGLE_270);
        end else if (ang >= ANGLE_180) begin
            data_next.quad = 2'd2;
            data_next.rem  = 7'(ang - ANGLE_180);
        end else if (ang >= ANGLE_90) begin
            data_next.quad = 2'd1;
            data_next.rem  = 7'(ang - ANGLE_90);
        end else begin
            data_next.quad = 2'd0;
            data_next.rem  = 7'(ang);
        end

        unique case (cfg.mode)
            MODE_REFL_X: begin
                data_next.dir_x = px13;
                data_next.dir_y = -py13;
            end
            MODE_REFL_Y: begin
                data_next.dir_x = -px13;
                data_next.dir_y = py13;
            end
            MODE_REFL_O: begin
                data_next.dir_x = -px13;
                data_next.dir_y = -py13;
            end
            MODE_SWAP: begin
                data_next.dir_x = py13;
                data_next.dir_y = px13;
            end
            default: begin
                data_next.dir_x = px13;
                data_next.dir_y = py13;
            end
        endcase
    end

    // Advance when the stage is empty or its request moves on
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: rtl/pt2d_mult.sv
`timescale 1ns / 1ps

module pt2d_mult import pt2d_pkg::*; #(
    parameter int TRIG_FRAC_BITS = 14
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  pt2d_s1_t                            in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output pt2d_ctl_t                           out_ctl,
    output logic signed [SPROD_W-1:0]           out_sx_prod,
    output logic signed [SPROD_W-1:0]           out_sy_prod,
    output logic signed [TRIG_FRAC_BITS+14:0]   out_dxc,
    output logic signed [TRIG_FRAC_BITS+14:0]   out_dys,
    output logic signed [TRIG_FRAC_BITS+14:0]   out_dxs,
    output logic signed [TRIG_FRAC_BITS+14:0]   out_dyc
);

    localparam int TW  = TRIG_FRAC_BITS + 1;
    localparam int TSW = TRIG_FRAC_BITS + 2;
    localparam int PRW = TRIG_FRAC_BITS + 15;

    // Trig stage
    logic                  v2_reg;
    pt2d_s1_t              d2_reg;
    logic signed [TSW-1:0] sin_reg;
    logic signed [TSW-1:0] cos_reg;
    logic signed [TSW-1:0] sin_next;
    logic signed [TSW-1:0] cos_next;

    // Product stage
    logic                      v3_reg;
    pt2d_ctl_t                 ctl_reg;
    logic signed [SPROD_W-1:0] sxp_reg;
    logic signed [SPROD_W-1:0] syp_reg;
    logic signed [PRW-1:0]     dxc_reg;
    logic signed [PRW-1:0]     dys_reg;
    logic signed [PRW-1:0]     dxs_reg;
    logic signed [PRW-1:0]     dyc_reg;

    logic en2;
    logic en3;

    logic [14:0]   e_lo_raw;
    logic [14:0]   e_hi_raw;
    logic [TW-1:0] e_lo;
    logic [TW-1:0] e_hi;

    // Look up the entries at the remainder and at its complement
    assign e_lo_raw = pt2d_sin_q14(in_data.rem);
    assign e_hi_raw = pt2d_sin_q14(DEG_90 - in_data.rem);

    // Rescale the Q1.14 entries to the trig fraction width
    generate
        if (TRIG_FRAC_BITS >= 14) begin : g_up
            assign e_lo = TW'(e_lo_raw) << (TRIG_FRAC_BITS - 14);
            assign e_hi = TW'(e_hi_raw) << (TRIG_FRAC_BITS - 14);
        end else begin : g_dn
            localparam int SH = 14 - TRIG_FRAC_BITS;
            localparam logic [14:0] RND = 15'(1 << (SH - 1));
            logic [14:0] lo_rnd;
            logic [14:0] hi_rnd;
            assign lo_rnd = e_lo_raw + RND;
            assign hi_rnd = e_hi_raw + RND;
            assign e_lo   = TW'(lo_rnd >> SH);
            assign e_hi   = TW'(hi_rnd >> SH);
        end
    endgenerate

    // Fold by quadrant: odd quadrants swap the entries, signs follow the quadrant
    always_comb begin
        logic signed [TSW-1:0] s_mag;
        logic signed [TSW-1:0] c_mag;
        s_mag = in_data.quad[0] ? $signed(TSW'(e_hi)) : $signed(TSW'(e_lo));
        c_mag = in_data.quad[0] ? $signed(TSW'(e_lo)) : $signed(TSW'(e_hi));
        sin_next = in_data.quad[1] ? -s_mag : s_mag;
        cos_next = (in_data.quad[1] ^ in_data.quad[0]) ? -c_mag : c_mag;
    end

    // Stall chain: a stage takes a request when empty or draining
    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign in_ready = en2;

    // Hold trig values with the request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en2) begin
            v2_reg <= in_valid;
        end
        if (en2 && in_valid) begin
            d2_reg  <= in_data;
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    // Multiply: scale products and the four rotation products
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en3) begin
            v3_reg <= v2_reg;
        end
        if (en3 && v2_reg) begin
            ctl_reg.mode  <= d2_reg.mode;
            ctl_reg.cx    <= d2_reg.cx;
            ctl_reg.cy    <= d2_reg.cy;
            ctl_reg.dir_x <= d2_reg.dir_x;
            ctl_reg.dir_y <= d2_reg.dir_y;
            sxp_reg <= SPROD_W'(d2_reg.px) * SPROD_W'(d2_reg.sx);
            syp_reg <= SPROD_W'(d2_reg.py) * SPROD_W'(d2_reg.sy);
            dxc_reg <= PRW'(d2_reg.dx) * PRW'(cos_reg);
            dys_reg <= PRW'(d2_reg.dy) * PRW'(sin_reg);
            dxs_reg <= PRW'(d2_reg.dx) * PRW'(sin_reg);
            dyc_reg <= PRW'(d2_reg.dy) * PRW'(cos_reg);
        end
    end

    assign out_valid   = v3_reg;
    assign out_ctl     = ctl_reg;
    assign out_sx_prod = sxp_reg;
    assign out_sy_prod = syp_reg;
    assign out_dxc     = dxc_reg;
    assign out_dys     = dys_reg;
    assign out_dxs     = dxs_reg;
    assign out_dyc     = dyc_reg;

endmodule

// File: rtl/pt2d_back.sv
`timescale 1ns / 1ps

module pt2d_back import pt2d_pkg::*; #(
    parameter int TRIG_FRAC_BITS = 14,
    parameter int OUT_BITS       = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  pt2d_ctl_t                         in_ctl,
    input  logic signed [SPROD_W-1:0]         in_sx_prod,
    input  logic signed [SPROD_W-1:0]         in_sy_prod,
    input  logic signed [TRIG_FRAC_BITS+14:0] in_dxc,
    input  logic signed [TRIG_FRAC_BITS+14:0] in_dys,
    input  logic signed [TRIG_FRAC_BITS+14:0] in_dxs,
    input  logic signed [TRIG_FRAC_BITS+14:0] in_dyc,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [OUT_BITS-1:0]        out_x,
    output logic signed [OUT_BITS-1:0]        out_y,
    output logic                              out_sat
);

    localparam int SUMW = TRIG_FRAC_BITS + 16;
    localparam int CW   = ((OUT_BITS > VAL_W) ? OUT_BITS : VAL_W) + 1;

    localparam logic signed [SUMW-1:0]    RBIAS = (SUMW'(1) <<< TRIG_FRAC_BITS) - SUMW'(1);
    localparam logic signed [SPROD_W-1:0] SBIAS = (SPROD_W'(1) <<< SCALE_SHIFT) - SPROD_W'(1);
    localparam logic signed [CW-1:0]      HI    = (CW'(1) <<< (OUT_BITS - 1)) - CW'(1);
    localparam logic signed [CW-1:0]      LO    = -(CW'(1) <<< (OUT_BITS - 1));

    logic                    v4_reg;
    logic signed [VAL_W-1:0] vx_reg;
    logic signed [VAL_W-1:0] vy_reg;
    logic signed [VAL_W-1:0] vx_next;
    logic signed [VAL_W-1:0] vy_next;

    logic                       v5_reg;
    logic signed [OUT_BITS-1:0] ox_reg;
    logic signed [OUT_BITS-1:0] oy_reg;
    logic                       sat_reg;
    logic signed [OUT_BITS-1:0] ox_next;
    logic signed [OUT_BITS-1:0] oy_next;
    logic                       sat_next;

    logic en4;
    logic en5;

    // Combine products and divide toward zero by a biased shift; other modes pass the direct results
    always_comb begin
        logic signed [SUMW-1:0]    sum_x;
        logic signed [SUMW-1:0]    sum_y;
        logic signed [SUMW-1:0]    rb_x;
        logic signed [SUMW-1:0]    rb_y;
        logic signed [SPROD_W-1:0] sb_x;
        logic signed [SPROD_W-1:0] sb_y;
        sum_x = (SUMW'(in_ctl.cx) <<< TRIG_FRAC_BITS) + SUMW'(in_dxc) - SUMW'(in_dys);
        sum_y = (SUMW'(in_ctl.cy) <<< TRIG_FRAC_BITS) + SUMW'(in_dxs) + SUMW'(in_dyc);
        rb_x  = sum_x + (sum_x[SUMW-1] ? RBIAS : '0);
        rb_y  = sum_y + (sum_y[SUMW-1] ? RBIAS : '0);
        sb_x  = in_sx_prod + (in_sx_prod[SPROD_W-1] ? SBIAS : '0);
        sb_y  = in_sy_prod + (in_sy_prod[SPROD_W-1] ? SBIAS : '0);
        unique case (in_ctl.mode)
            MODE_SCALE: begin
                vx_next = VAL_W'(sb_x >>> SCALE_SHIFT);
                vy_next = VAL_W'(sb_y >>> SCALE_SHIFT);
            end
            MODE_ROTATE: begin
                vx_next = VAL_W'(rb_x >>> TRIG_FRAC_BITS);
                vy_next = VAL_W'(rb_y >>> TRIG_FRAC_BITS);
            end
            default: begin
                vx_next = VAL_W'(in_ctl.dir_x);
                vy_next = VAL_W'(in_ctl.dir_y);
            end
        endcase
    end

    // Clip each coordinate to the output range
    always_comb begin
        logic signed [CW-1:0] ex;
        logic signed [CW-1:0] ey;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic                 clip_x;
        logic                 clip_y;
        ex = CW'(vx_reg);
        ey = CW'(vy_reg);
        clip_x = (ex > HI) || (ex < LO);
        clip_y = (ey > HI) || (ey < LO);
        cx = (ex > HI) ? HI : ((ex < LO) ? LO : ex);
        cy = (ey > HI) ? HI : ((ey < LO) ? LO : ey);
        ox_next  = cx[OUT_BITS-1:0];
        oy_next  = cy[OUT_BITS-1:0];
        sat_next = clip_x || clip_y;
    end

    // Stall chain through the output register
    assign en5      = !v5_reg || out_ready;
    assign en4      = !v4_reg || en5;
    assign in_ready = en4;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (en4) begin
                v4_reg <= in_valid;
            end
            if (en5) begin
                v5_reg <= v4_reg;
            end
        end
        if (en4 && in_valid) begin
            vx_reg <= vx_next;
            vy_reg <= vy_next;
        end
        if (en5 && v4_reg) begin
            ox_reg  <= ox_next;
            oy_reg  <= oy_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;
    assign out_sat   = sat_reg;

endmodule

// File: rtl/point_transform_2d_top.sv
`timescale 1ns / 1ps
// 2-D point transform: scale, reflect, swap or rotate one vertex per request.
// Input stream s_*: one vertex per request, taken when s_tvalid and s_tready
// are both high. Output stream m_*: one transformed vertex per input vertex,
// in order, with m_tuser flagging that a coordinate was clipped.
// The configuration port writes a register on any edge where cfg_wen is
// high; change it only while no request is in flight.
// Pipeline: five register stages (decode, trig lookup, multiply, combine,
// clip and output). Throughput: one vertex per cycle unless m_tready
// stalls the pipe; the multiply stage has a full set of multipliers, so
// nothing is shared.
// Stall: every stage advances when empty or when the stage after it moves,
// so bubbles close up and s_tready only falls once the pipe is full behind a
// stalled receiver. Nothing is dropped or repeated.
// Reset: stage valid bits clear, the output goes idle, and the registers
// return to scale mode with unit factors, zero angle and a pivot at zero.
`include "point_transform_2d_top_assert.svh"

module point_transform_2d_top import pt2d_pkg::*; #(
    parameter int TRIG_FRAC_BITS = 14,
    parameter int OUT_BITS       = 16
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // point_x [11:0], point_y [23:12]
    input  logic [23:0]                             s_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // out_x, then out_y, each OUT_BITS wide, zero padded to whole bytes
    output logic [((2 * OUT_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    // saturated [0]
    output logic [0:0]                              m_tuser,
    input  logic                                    cfg_wen,
    input  logic [CFG_IDX_W-1:0]                    cfg_idx,
    input  logic [CFG_DATA_W-1:0]                   cfg_wdata
);

    localparam int TDW = ((2 * OUT_BITS + 7) / 8) * 8;
    localparam int PRW = TRIG_FRAC_BITS + 15;

    localparam logic signed [OUT_BITS-1:0] OUT_MAX = (OUT_BITS'(1) <<< (OUT_BITS - 1)) - 1'b1;
    localparam logic signed [OUT_BITS-1:0] OUT_MIN = OUT_BITS'(1) <<< (OUT_BITS - 1);

    pt2d_cfg_t cfg_reg;

    logic      s1_valid;
    logic      s1_ready;
    pt2d_s1_t  s1_data;

    logic                      s3_valid;
    logic                      s3_ready;
    pt2d_ctl_t                 s3_ctl;
    logic signed [SPROD_W-1:0] s3_sxp;
    logic signed [SPROD_W-1:0] s3_syp;
    logic signed [PRW-1:0]     s3_dxc;
    logic signed [PRW-1:0]     s3_dys;
    logic signed [PRW-1:0]     s3_dxs;
    logic signed [PRW-1:0]     s3_dyc;

    logic signed [OUT_BITS-1:0] out_x;
    logic signed [OUT_BITS-1:0] out_y;
    logic                       out_sat;
    logic                       in_acc;

    // Write the configuration registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_wen) begin
            unique case (cfg_idx)
                REG_MODE:    cfg_reg.mode      <= cfg_wdata[2:0];
                REG_SCALE_X: cfg_reg.scale_x   <= $signed(cfg_wdata);
                REG_SCALE_Y: cfg_reg.scale_y   <= $signed(cfg_wdata);
                REG_ANGLE:   cfg_reg.angle_deg <= cfg_wdata[8:0];
                REG_PIVOT_X: cfg_reg.pivot_x   <= $signed(cfg_wdata[11:0]);
                REG_PIVOT_Y: cfg_reg.pivot_y   <= $signed(cfg_wdata[11:0]);
                default: begin
                end
            endcase
        end
    end

    pt2d_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .point_x   ($signed(s_tdata[11:0])),
        .point_y   ($signed(s_tdata[23:12])),
        .cfg       (cfg_reg),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    pt2d_mult #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_mult (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s1_valid),
        .in_ready    (s1_ready),
        .in_data     (s1_data),
        .out_valid   (s3_valid),
        .out_ready   (s3_ready),
        .out_ctl     (s3_ctl),
        .out_sx_prod (s3_sxp),
        .out_sy_prod (s3_syp),
        .out_dxc     (s3_dxc),
        .out_dys     (s3_dys),
        .out_dxs     (s3_dxs),
        .out_dyc     (s3_dyc)
    );

    pt2d_back #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS),
        .OUT_BITS       (OUT_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s3_valid),
        .in_ready   (s3_ready),
        .in_ctl     (s3_ctl),
        .in_sx_prod (s3_sxp),
        .in_sy_prod (s3_syp),
        .in_dxc     (s3_dxc),
        .in_dys     (s3_dys),
        .in_dxs     (s3_dxs),
        .in_dyc     (s3_dyc),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_sat    (out_sat)
    );

    // Pack the result
    assign m_tdata    = TDW'({out_y, out_x});
    assign m_tuser[0] = out_sat;

    assign in_acc = s_tvalid && s_tready;

    // A request with the receiver ready throughout reaches the output
    `PT2D_ASSERT_NXT(a_latency, $past(in_acc, 4) && $past(aresetn, 4) && $past(aresetn, 3) && $past(aresetn, 2) && $past(aresetn, 1) && $past(m_tready, 3) && $past(m_tready, 2) && $past(m_tready, 1) && m_tready, m_tvalid, "request lost in pipeline")

    // A clipped result sits on a range limit
    `PT2D_ASSERT_IMP(a_sat_limit, m_tvalid && m_tuser[0], out_x == OUT_MAX || out_x == OUT_MIN || out_y == OUT_MAX || out_y == OUT_MIN, "saturated flag without a clipped coordinate")

    // Reset empties the pipe and opens the input
    `PT2D_ASSERT_NXT_RST(a_reset_idle, !aresetn, !m_tvalid && s_tready, "pipeline not empty after reset")

endmodule
